FILE: rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// shared widths, constants and types of the de casteljau bezier evaluator
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_WIDTH = 18;
    localparam int T_WIDTH     = 17;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = DIFF_W + T_WIDTH + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = SUM_W - FRAC_BITS;

    localparam int S_DATA_W = ((2 * COORD_WIDTH + T_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int S_USER_W = 2;
    localparam int M_USER_W = 2;

    localparam logic [T_WIDTH-1:0] T_ONE    = T_WIDTH'(1 << FRAC_BITS);
    localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1 << (FRAC_BITS - 1));

    // minimum level length that lets the next level start without a bubble
    localparam int OVERLAP_MIN = 5;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

endpackage

FILE: rtl/bezier_de_casteljau_evaluator_top.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_evaluator_top
// control polygon store and de casteljau curve evaluation in q2.16 fixed point
// ----------------------------------------------------------------------------
// load word: no result word
// evaluate word: the levels run through the single shared lerp pipeline, which
//   reads one control or scratch point per cycle while a level streams and
//   pauses to drain before a short level; an empty store answers with a zero point
// one word in flight at a time; a load may be taken while a result waits
// aresetn (synchronous, active low) clears point count, overflow flag, fsm
//   and output valid; the point memories keep their contents
module bezier_de_casteljau_evaluator_top
    import bdc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // point_x[17:0], point_y[35:18], param_t[52:36]
    input  logic [S_USER_W-1:0] s_tuser,  // func[0], restart[1]
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // curve_x[17:0], curve_y[35:18]
    output logic [M_USER_W-1:0] m_tuser   // empty_res[0], overflowed[1]
);

    // fsm codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;  // stream one level through the lerp
    localparam logic [2:0] ST_WAIT = 3'd2;  // drain before a short level
    localparam logic [2:0] ST_FIN  = 3'd3;  // drain, then read point 0
    localparam logic [2:0] ST_FINQ = 3'd4;  // point 0 read data arrives
    localparam logic [2:0] ST_DONE = 3'd5;  // hand result to output register

    // input word fields
    logic             in_func;
    logic             in_restart;
    coord_t           in_x;
    coord_t           in_y;
    logic [T_WIDTH-1:0] in_t;

    assign in_func    = s_tuser[0];
    assign in_restart = s_tuser[1];
    assign in_x       = s_tdata[COORD_WIDTH-1:0];
    assign in_y       = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign in_t       = s_tdata[2*COORD_WIDTH+T_WIDTH-1:2*COORD_WIDTH];

    // control state
    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [T_WIDTH-1:0] t_reg, t_next;
    logic [CNT_W-1:0]   len_reg, len_next;     // source points in current level
    logic [ADDR_W-1:0]  idx_reg, idx_next;     // read index within level
    logic               src_ctl_reg, src_ctl_next;  // read control store, not scratch

    // result holding
    point_t res_reg, res_next;
    logic   res_empty_reg, res_empty_next;
    logic   res_ovf_reg, res_ovf_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    point_t             m_pt_reg, m_pt_next;
    logic               m_empty_reg, m_empty_next;
    logic               m_ovf_reg, m_ovf_next;

    // memories
    point_t ctl_mem [MAX_POINTS];
    point_t scr_mem [MAX_POINTS];
    point_t ctl_q_reg;
    point_t scr_q_reg;

    // lerp pipeline
    logic              rd_issue;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr;
    logic              s1_vld_reg;
    logic              s1_first_reg;
    logic              s1_ctl_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    point_t            s1_data;

    point_t                   prev_reg;
    logic                     s2_vld_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic signed [DIFF_W-1:0] s2_dx_reg, s2_dy_reg;
    point_t                   s2_a_reg;

    logic                     s3_vld_reg;
    logic [ADDR_W-1:0]        s3_addr_reg;
    logic signed [PROD_W-1:0] s3_px_reg, s3_py_reg;
    point_t                   s3_a_reg;

    point_t wr_pt;
    logic   pipe_empty;
    logic   s_accept;
    logic   out_free;
    logic   load_ok;
    logic [ADDR_W-1:0] load_addr;

    assign s_accept   = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_tready;
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;

    // a restart always leaves room for its point
    assign load_ok   = in_restart || (count_reg < CNT_W'(MAX_POINTS));
    assign load_addr = in_restart ? '0 : count_reg[ADDR_W-1:0];

    // round to nearest, ties up: a + floor((p + half) / 2^16)
    function automatic coord_t lerp_out(input coord_t a, input logic signed [PROD_W-1:0] p);
        logic signed [SUM_W-1:0] sum;
        logic signed [SHR_W-1:0] shr;
        logic signed [SHR_W-1:0] tot;
        sum = SUM_W'(p) + ROUND_HALF;
        shr = sum[SUM_W-1:FRAC_BITS];
        tot = shr + SHR_W'(a);
        return tot[COORD_WIDTH-1:0];
    endfunction

    assign wr_pt.x = lerp_out(s3_a_reg.x, s3_px_reg);
    assign wr_pt.y = lerp_out(s3_a_reg.y, s3_py_reg);
    assign s1_data = s1_ctl_reg ? ctl_q_reg : scr_q_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        t_next         = t_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        src_ctl_next   = src_ctl_reg;
        res_next       = res_reg;
        res_empty_next = res_empty_reg;
        res_ovf_next   = res_ovf_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_pt_next      = m_pt_reg;
        m_empty_next   = m_empty_reg;
        m_ovf_next     = m_ovf_reg;
        rd_issue       = 1'b0;
        rd_first       = 1'b0;
        rd_addr        = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_func == FUNC_LOAD) begin
                    if (in_restart) begin
                        ovf_next = 1'b0;
                    end
                    if (load_ok) begin
                        count_next = CNT_W'(load_addr) + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end else if (s_accept) begin
                    t_next         = (in_t > T_ONE) ? T_ONE : in_t;
                    len_next       = count_reg;
                    idx_next       = '0;
                    src_ctl_next   = 1'b1;
                    res_ovf_next   = ovf_reg;
                    res_empty_next = 1'b0;
                    if (count_reg == '0) begin
                        res_next       = '0;
                        res_empty_next = 1'b1;
                        state_next     = ST_DONE;
                    end else if (count_reg == CNT_W'(1)) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rd_issue = 1'b1;
                rd_first = (idx_reg == '0);
                if ({1'b0, idx_reg} == len_reg - CNT_W'(1)) begin
                    idx_next     = '0;
                    len_next     = len_reg - CNT_W'(1);
                    src_ctl_next = 1'b0;
                    if (len_reg == CNT_W'(2)) begin
                        state_next = ST_FIN;
                    end else if (len_reg < CNT_W'(OVERLAP_MIN)) begin
                        // next level would read points before they are written
                        state_next = ST_WAIT;
                    end
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            ST_WAIT: begin
                if (pipe_empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_FIN: begin
                rd_addr = '0;
                if (pipe_empty) begin
                    state_next = ST_FINQ;
                end
            end
            ST_FINQ: begin
                res_next   = src_ctl_reg ? ctl_q_reg : scr_q_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pt_next    = res_reg;
                    m_empty_next = res_empty_reg;
                    m_ovf_next   = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            s1_vld_reg  <= rd_issue;
            s2_vld_reg  <= s1_vld_reg && !s1_first_reg;
            s3_vld_reg  <= s2_vld_reg;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        t_reg         <= t_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        src_ctl_reg   <= src_ctl_next;
        res_reg       <= res_next;
        res_empty_reg <= res_empty_next;
        res_ovf_reg   <= res_ovf_next;
        m_pt_reg      <= m_pt_next;
        m_empty_reg   <= m_empty_next;
        m_ovf_reg     <= m_ovf_next;
    end

    // control point store
    always_ff @(posedge aclk) begin
        if (s_accept && in_func == FUNC_LOAD && load_ok) begin
            ctl_mem[load_addr] <= '{y: in_y, x: in_x};
        end
        ctl_q_reg <= ctl_mem[rd_addr];
    end

    // scratch store, written by the lerp pipeline
    always_ff @(posedge aclk) begin
        if (s3_vld_reg) begin
            scr_mem[s3_addr_reg] <= wr_pt;
        end
        scr_q_reg <= scr_mem[rd_addr];
    end

    // lerp pipeline: read, difference, multiply, round and write back
    always_ff @(posedge aclk) begin
        s1_first_reg <= rd_first;
        s1_ctl_reg   <= src_ctl_reg;
        s1_idx_reg   <= rd_addr;
        if (s1_vld_reg) begin
            prev_reg <= s1_data;
        end
        s2_addr_reg <= s1_idx_reg - ADDR_W'(1);
        s2_dx_reg   <= DIFF_W'(s1_data.x) - DIFF_W'(prev_reg.x);
        s2_dy_reg   <= DIFF_W'(s1_data.y) - DIFF_W'(prev_reg.y);
        s2_a_reg    <= prev_reg;
        s3_addr_reg <= s2_addr_reg;
        s3_px_reg   <= PROD_W'(s2_dx_reg) * PROD_W'(signed'({1'b0, t_reg}));
        s3_py_reg   <= PROD_W'(s2_dy_reg) * PROD_W'(signed'({1'b0, t_reg}));
        s3_a_reg    <= s2_a_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 2*COORD_WIDTH){1'b0}}, m_pt_reg.y, m_pt_reg.x};
    assign m_tuser  = {m_ovf_reg, m_empty_reg};

endmodule

FILE: rtl/bdc_checker.sv
// ----------------------------------------------------------------------------
// bdc_checker
// port level checks of the bezier evaluator, bound to the top level
// ----------------------------------------------------------------------------
module bdc_checker
    import bdc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // empty store gives a zero point
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("empty result with nonzero point");

    // a load never produces a result word
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == FUNC_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("result word after a load");

    // no result appears in the cycle right after an accepted word
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result word too early");

endmodule

bind bezier_de_casteljau_evaluator_top bdc_checker u_bdc_checker (.*);
